@@ design/base90_run_length_grid_decoder_unit_defines.svh @@
//------------------------------------------------------------------------------
// Grid decoder assertion macros
// Concurrent checks sampled on clock and disabled during reset.
//------------------------------------------------------------------------------
`ifndef BASE90_RUN_LENGTH_GRID_DECODER_UNIT_DEFINES_SVH
`define BASE90_RUN_LENGTH_GRID_DECODER_UNIT_DEFINES_SVH

// check in the same cycle
`define BGD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// check in the next cycle
`define BGD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/bgd_pkg.sv @@
//------------------------------------------------------------------------------
// Grid decoder package
// Shared constants, register indexes, codes and control types.
//------------------------------------------------------------------------------
package bgd_pkg;

   localparam int MAX_DIGITS_DEF = 20;
   localparam int ROW_BITS_DEF   = 16;

   localparam logic [7:0]  CHAR_LF     = 8'd10;
   localparam logic [7:0]  CHAR_CR     = 8'd13;
   localparam logic [7:0]  CHAR_BANG   = 8'd33;
   localparam logic [7:0]  CHAR_QUOTE  = 8'd34;
   localparam logic [31:0] DIGIT_BIAS  = 32'd37;
   localparam logic [31:0] RADIX       = 32'd90;

   localparam logic [2:0] CSR_DIGITS = 3'd0;
   localparam logic [2:0] CSR_ROWLEN = 3'd1;
   localparam logic [2:0] CSR_SCALE  = 3'd2;
   localparam logic [2:0] CSR_OFFSET = 3'd3;
   localparam logic [2:0] CSR_DUMMY  = 3'd4;

   localparam logic [4:0]  DIGITS_RST = 5'd1;
   localparam logic [15:0] ROWLEN_RST = 16'd1;
   localparam logic [31:0] SCALE_RST  = 32'd65536;
   localparam logic [47:0] OFFSET_RST = 48'd0;
   localparam logic [63:0] DUMMY_RST  = 64'hFF17_2B5A_F000_0000;

   localparam logic [1:0] ERR_NONE = 2'd0;
   localparam logic [1:0] ERR_CUT  = 2'd1;
   localparam logic [1:0] ERR_RUN  = 2'd2;

   typedef enum logic [1:0] {
      PH_TOKEN,
      PH_MARKER,
      PH_COUNT,
      PH_VALUE
   } bgd_phase_type;

   typedef enum logic [1:0] {
      RES_NONE,
      RES_ERR,
      RES_DUMMY,
      RES_SCALED
   } bgd_res_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STEP,
      ST_MUL,
      ST_SUM,
      ST_EMIT
   } bgd_state_type;

   typedef struct packed {
      logic capture;
      logic step;
      logic mul;
      logic sum;
      logic load_out;
   } bgd_cmd_type;

   typedef struct packed {
      logic has_result;
      logic is_scaled;
      logic out_free;
   } bgd_status_type;

endpackage

@@ design/bgd_if.sv @@
//------------------------------------------------------------------------------
// Grid decoder channels
// Request, response and register write channels with valid/ready.
//------------------------------------------------------------------------------
interface bgd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;

   modport source (output valid, output text_byte, input ready);
   modport sink   (input valid, input text_byte, output ready);
endinterface

interface bgd_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [63:0] grid_value;
   logic [15:0]        run_count;
   logic               is_dummy;
   logic               row_end;
   logic [1:0]         error_code;

   modport source (output valid, output grid_value, output run_count, output is_dummy,
                   output row_end, output error_code, input ready);
   modport sink   (input valid, input grid_value, input run_count, input is_dummy,
                   input row_end, input error_code, output ready);
endinterface

interface bgd_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [63:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/bgd_datapath.sv @@
//------------------------------------------------------------------------------
// Grid decoder datapath
// Token state, register file, scaling multiplier and response register.
//------------------------------------------------------------------------------
`include "base90_run_length_grid_decoder_unit_defines.svh"

module bgd_datapath #(
   parameter int MAX_DIGITS = bgd_pkg::MAX_DIGITS_DEF,
   parameter int ROW_BITS   = bgd_pkg::ROW_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [7:0]              text_byte,
   input  bgd_pkg::bgd_cmd_type    cmd,
   output bgd_pkg::bgd_status_type status,
   bgd_csr_if.sink                 csr,
   bgd_rsp_if.source               rsp
);

   localparam logic [31:0] RowMask = 32'((64'd1 << ROW_BITS) - 64'd1);

   logic [4:0]         digits_ff;
   logic [15:0]        rowlen_ff;
   logic signed [31:0] scale_ff;
   logic signed [47:0] offset_ff;
   logic signed [63:0] dummy_ff;

   bgd_pkg::bgd_phase_type phase_ff, phase_in;
   logic [4:0]             dc_ff, dc_in;
   logic [31:0]            acc_ff, acc_in;
   logic [31:0]            pend_ff, pend_in;
   logic                   tdum_ff, tdum_in;
   logic                   brk_ff, brk_in;
   logic [ROW_BITS-1:0]    vir_ff, vir_in;
   logic                   drop_ff, drop_in;

   logic [7:0]           byte_ff;
   bgd_pkg::bgd_res_type res_kind_ff, res_kind;
   logic [1:0]           res_code_ff, res_code;
   logic [15:0]          res_run_ff, res_run;
   logic                 res_end_ff, res_end;
   logic [31:0]          raw_ff;
   logic signed [63:0]   prod_ff;
   logic signed [63:0]   sum_ff;

   logic                 rsp_valid_ff;
   logic signed [63:0]   rsp_value_ff;
   logic [15:0]          rsp_run_ff;
   logic                 rsp_dummy_ff;
   logic                 rsp_end_ff;
   logic [1:0]           rsp_code_ff;

   logic [4:0]          n_eff;
   logic [31:0]         row32;
   logic [ROW_BITS-1:0] rowlen;
   logic [ROW_BITS-1:0] vir_eff;
   logic [ROW_BITS-1:0] left;
   logic [31:0]         acc_next;
   logic [4:0]          dc_next;
   logic                is_eol;
   logic signed [64:0]  prod_full;
   logic signed [64:0]  sum_full;

   always_comb begin
      if (digits_ff == 5'd0) begin
         n_eff = 5'd1;
      end else if (32'(digits_ff) > 32'(MAX_DIGITS)) begin
         n_eff = 5'(MAX_DIGITS);
      end else begin
         n_eff = digits_ff;
      end
      row32   = {16'd0, rowlen_ff} & RowMask;
      rowlen  = (row32[ROW_BITS-1:0] == '0) ? ROW_BITS'(1) : row32[ROW_BITS-1:0];
      vir_eff = (vir_ff >= rowlen) ? '0 : vir_ff;
      left    = rowlen - vir_eff;
      acc_next = 32'(acc_ff * bgd_pkg::RADIX) + (32'(byte_ff) - bgd_pkg::DIGIT_BIAS);
      dc_next  = dc_ff + 5'd1;
      is_eol   = (byte_ff == bgd_pkg::CHAR_LF) || (byte_ff == bgd_pkg::CHAR_CR);
   end

   always_comb begin
      logic [31:0]            run_sel;
      logic [ROW_BITS-1:0]    vir_sum;
      logic                   do_err;
      logic                   do_emit;
      logic [1:0]             err_code;
      bgd_pkg::bgd_phase_type ph_tmp;

      phase_in = phase_ff;
      dc_in    = dc_ff;
      acc_in   = acc_ff;
      pend_in  = pend_ff;
      tdum_in  = tdum_ff;
      brk_in   = brk_ff;
      vir_in   = vir_eff;
      drop_in  = drop_ff;
      res_kind = bgd_pkg::RES_NONE;
      res_code = bgd_pkg::ERR_NONE;
      res_run  = 16'd0;
      res_end  = 1'b0;
      run_sel  = 32'd1;
      vir_sum  = '0;
      do_err   = 1'b0;
      do_emit  = 1'b0;
      err_code = bgd_pkg::ERR_CUT;
      ph_tmp   = phase_ff;

      if (is_eol) begin
         if (drop_ff) begin
            drop_in  = 1'b0;
            phase_in = bgd_pkg::PH_TOKEN;
            dc_in    = 5'd0;
            acc_in   = 32'd0;
            tdum_in  = 1'b0;
            brk_in   = 1'b0;
         end else if (phase_ff == bgd_pkg::PH_TOKEN || phase_ff == bgd_pkg::PH_MARKER) begin
            do_err = (dc_ff != 5'd0);
         end else if (brk_ff) begin
            do_err = 1'b1;
         end else begin
            brk_in  = 1'b1;
            dc_in   = 5'd0;
            acc_in  = 32'd0;
            tdum_in = 1'b0;
         end
      end else if (!drop_ff) begin
         if (dc_ff == 5'd0) begin
            tdum_in = (byte_ff == bgd_pkg::CHAR_BANG);
            if (phase_ff == bgd_pkg::PH_TOKEN && byte_ff == bgd_pkg::CHAR_QUOTE) begin
               ph_tmp = bgd_pkg::PH_MARKER;
            end
         end
         phase_in = ph_tmp;
         acc_in   = acc_next;
         dc_in    = dc_next;
         if (dc_next >= n_eff) begin
            brk_in  = 1'b0;
            dc_in   = 5'd0;
            acc_in  = 32'd0;
            case (ph_tmp)
               bgd_pkg::PH_MARKER: begin
                  phase_in = bgd_pkg::PH_COUNT;
                  tdum_in  = 1'b0;
               end
               bgd_pkg::PH_COUNT: begin
                  pend_in  = acc_next;
                  phase_in = bgd_pkg::PH_VALUE;
                  tdum_in  = 1'b0;
               end
               bgd_pkg::PH_VALUE: begin
                  phase_in = bgd_pkg::PH_TOKEN;
                  run_sel  = pend_ff;
                  if (pend_ff > 32'(left)) begin
                     do_err   = 1'b1;
                     err_code = bgd_pkg::ERR_RUN;
                  end else if (pend_ff == 32'd0) begin
                     tdum_in = 1'b0;
                  end else begin
                     do_emit = 1'b1;
                  end
               end
               default: begin
                  do_emit = 1'b1;
               end
            endcase
         end
      end

      if (do_err) begin
         phase_in = bgd_pkg::PH_TOKEN;
         dc_in    = 5'd0;
         acc_in   = 32'd0;
         tdum_in  = 1'b0;
         pend_in  = 32'd0;
         brk_in   = 1'b0;
         vir_in   = '0;
         drop_in  = (err_code == bgd_pkg::ERR_RUN);
         res_kind = bgd_pkg::RES_ERR;
         res_code = err_code;
      end else if (do_emit) begin
         res_kind = tdum_in ? bgd_pkg::RES_DUMMY : bgd_pkg::RES_SCALED;
         res_run  = run_sel[15:0];
         tdum_in  = 1'b0;
         pend_in  = 32'd0;
         vir_sum  = vir_eff + run_sel[ROW_BITS-1:0];
         vir_in   = vir_sum;
         if (vir_sum >= rowlen) begin
            res_end = 1'b1;
            vir_in  = '0;
            drop_in = 1'b1;
         end
      end
   end

   assign prod_full = $signed({1'b0, raw_ff}) * $signed(scale_ff);
   assign sum_full  = {prod_ff[63], prod_ff} + {{17{offset_ff[47]}}, offset_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         digits_ff <= bgd_pkg::DIGITS_RST;
         rowlen_ff <= bgd_pkg::ROWLEN_RST;
         scale_ff  <= bgd_pkg::SCALE_RST;
         offset_ff <= bgd_pkg::OFFSET_RST;
         dummy_ff  <= bgd_pkg::DUMMY_RST;
      end else if (csr.valid) begin
         case (csr.index)
            bgd_pkg::CSR_DIGITS: digits_ff <= csr.data[4:0];
            bgd_pkg::CSR_ROWLEN: rowlen_ff <= csr.data[15:0];
            bgd_pkg::CSR_SCALE:  scale_ff  <= csr.data[31:0];
            bgd_pkg::CSR_OFFSET: offset_ff <= csr.data[47:0];
            bgd_pkg::CSR_DUMMY:  dummy_ff  <= csr.data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= bgd_pkg::PH_TOKEN;
         dc_ff    <= 5'd0;
         acc_ff   <= 32'd0;
         pend_ff  <= 32'd0;
         tdum_ff  <= 1'b0;
         brk_ff   <= 1'b0;
         vir_ff   <= '0;
         drop_ff  <= 1'b0;
      end else if (cmd.step) begin
         phase_ff <= phase_in;
         dc_ff    <= dc_in;
         acc_ff   <= acc_in;
         pend_ff  <= pend_in;
         tdum_ff  <= tdum_in;
         brk_ff   <= brk_in;
         vir_ff   <= vir_in;
         drop_ff  <= drop_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         byte_ff <= text_byte;
      end
      if (cmd.step) begin
         res_kind_ff <= res_kind;
         res_code_ff <= res_code;
         res_run_ff  <= res_run;
         res_end_ff  <= res_end;
         raw_ff      <= acc_next;
      end
      if (cmd.mul) begin
         prod_ff <= prod_full[63:0];
      end
      if (cmd.sum) begin
         if (sum_full[64] != sum_full[63]) begin
            sum_ff <= sum_full[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
         end else begin
            sum_ff <= sum_full[63:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         case (res_kind_ff)
            bgd_pkg::RES_DUMMY:  rsp_value_ff <= dummy_ff;
            bgd_pkg::RES_SCALED: rsp_value_ff <= sum_ff;
            default:             rsp_value_ff <= 64'sd0;
         endcase
         rsp_run_ff   <= res_run_ff;
         rsp_dummy_ff <= (res_kind_ff == bgd_pkg::RES_DUMMY);
         rsp_end_ff   <= res_end_ff;
         rsp_code_ff  <= res_code_ff;
      end
   end

   assign status.has_result = (res_kind != bgd_pkg::RES_NONE);
   assign status.is_scaled  = (res_kind == bgd_pkg::RES_SCALED);
   assign status.out_free   = !rsp_valid_ff || rsp.ready;

   assign csr.ready      = 1'b1;
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.grid_value = rsp_value_ff;
   assign rsp.run_count  = rsp_run_ff;
   assign rsp.is_dummy   = rsp_dummy_ff;
   assign rsp.row_end    = rsp_end_ff;
   assign rsp.error_code = rsp_code_ff;

   `BGD_ASSERT_NOW(a_err_empty,
                   rsp_valid_ff && rsp_code_ff != bgd_pkg::ERR_NONE,
                   rsp_run_ff == 16'd0 && !rsp_end_ff && !rsp_dummy_ff,
                   "error response carries payload")
   `BGD_ASSERT_NOW(a_ok_run,
                   rsp_valid_ff && rsp_code_ff == bgd_pkg::ERR_NONE,
                   rsp_run_ff != 16'd0,
                   "good response with zero run")
   `BGD_ASSERT_NEXT(a_rsp_hold,
                    rsp_valid_ff && !rsp.ready,
                    rsp_valid_ff,
                    "stalled response dropped")

endmodule

@@ design/bgd_controller.sv @@
//------------------------------------------------------------------------------
// Grid decoder controller
// Sequences capture, token step, multiply, offset add and response load.
//------------------------------------------------------------------------------
`include "base90_run_length_grid_decoder_unit_defines.svh"

module bgd_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  bgd_pkg::bgd_status_type status,
   output bgd_pkg::bgd_cmd_type    cmd
);

   bgd_pkg::bgd_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bgd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bgd_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = bgd_pkg::ST_STEP;
            end
         end
         bgd_pkg::ST_STEP: begin
            if (!status.has_result) begin
               state_in = bgd_pkg::ST_IDLE;
            end else if (status.is_scaled) begin
               state_in = bgd_pkg::ST_MUL;
            end else begin
               state_in = bgd_pkg::ST_EMIT;
            end
         end
         bgd_pkg::ST_MUL: state_in = bgd_pkg::ST_SUM;
         bgd_pkg::ST_SUM: state_in = bgd_pkg::ST_EMIT;
         bgd_pkg::ST_EMIT: begin
            if (status.out_free) begin
               state_in = bgd_pkg::ST_IDLE;
            end
         end
         default: state_in = bgd_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      cmd.capture  = 1'b0;
      cmd.step     = 1'b0;
      cmd.mul      = 1'b0;
      cmd.sum      = 1'b0;
      cmd.load_out = 1'b0;
      case (state_ff)
         bgd_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         bgd_pkg::ST_STEP: cmd.step = 1'b1;
         bgd_pkg::ST_MUL:  cmd.mul  = 1'b1;
         bgd_pkg::ST_SUM:  cmd.sum  = 1'b1;
         bgd_pkg::ST_EMIT: cmd.load_out = status.out_free;
         default: begin
         end
      endcase
   end

   `BGD_ASSERT_NEXT(a_accept_step, req_valid && req_ready, state_ff == bgd_pkg::ST_STEP, "accepted request did not start a step")
   `BGD_ASSERT_NEXT(a_mul_sum, state_ff == bgd_pkg::ST_MUL, state_ff == bgd_pkg::ST_SUM, "multiply not followed by offset add")
   `BGD_ASSERT_NEXT(a_emit_idle, cmd.load_out, state_ff == bgd_pkg::ST_IDLE && !req_valid || state_ff == bgd_pkg::ST_IDLE, "response load did not return to idle")

endmodule

@@ design/base90_run_length_grid_decoder_unit.sv @@
// Sequence: a text byte that yields no result is accepted, then stepped.
// A dummy or error result is loaded into the response register after the step;
// a scaled value first passes through the 33x32 multiplier and the add.
// A byte is taken only when the last is done; a load waits for a free output.
// Reset: synchronous; clears token state, row position and registers to defaults.
//------------------------------------------------------------------------------
// Base-90 run-length grid decoder
// Decodes compressed grid text into scaled, run-length values per row.
//------------------------------------------------------------------------------
module base90_run_length_grid_decoder_unit #(
   parameter int MAX_DIGITS = bgd_pkg::MAX_DIGITS_DEF,
   parameter int ROW_BITS   = bgd_pkg::ROW_BITS_DEF
) (
   input logic       clock,
   input logic       reset,
   bgd_req_if.sink   req_if,
   bgd_rsp_if.source rsp_if,
   bgd_csr_if.sink   csr_if
);

   bgd_pkg::bgd_cmd_type    cmd;
   bgd_pkg::bgd_status_type status;
   logic                    ctl_req_ready;

   bgd_controller u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (ctl_req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bgd_datapath #(
      .MAX_DIGITS (MAX_DIGITS),
      .ROW_BITS   (ROW_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .text_byte (req_if.text_byte),
      .cmd       (cmd),
      .status    (status),
      .csr       (csr_if),
      .rsp       (rsp_if)
   );

   assign req_if.ready = ctl_req_ready;

endmodule
